// ===== src/hsc_pkg.sv =====
// shared types, codes and helper function of the heightmap splat classifier
package hsc_pkg;

  // operation codes carried from the front to the back
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DROP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_GRID_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_WATER_LEVEL  = 3'd2;
  localparam logic [2:0] CFG_SPLAT_RADIUS = 3'd3;
  localparam logic [2:0] CFG_SPLAT_POWER  = 3'd4;

  // terrain classes
  localparam logic [2:0] CLS_DEEP     = 3'd0;
  localparam logic [2:0] CLS_SHALLOW  = 3'd1;
  localparam logic [2:0] CLS_COAST    = 3'd2;
  localparam logic [2:0] CLS_PLAINS   = 3'd3;
  localparam logic [2:0] CLS_FOREST   = 3'd4;
  localparam logic [2:0] CLS_MOUNTAIN = 3'd5;

  // output field widths
  localparam int RAW_W = 24;

  // floor(n/100) as (n*RECIP_100) >> RECIP_SHIFT, exact for n below 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] x_pos;
    logic [5:0] y_pos;
  } cmd_t;

  typedef struct packed {
    logic [6:0] grid_width;
    logic [6:0] grid_height;
    logic [7:0] water_level;
    logic [3:0] splat_radius;
    logic [7:0] splat_power;
  } cfg_t;

  // floor square root of an 8-bit value, compare against every square
  function automatic logic [3:0] isqrt8(input logic [7:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 1; i < 16; i++) begin
      if (int'(v) >= i * i) r = 4'(i);
    end
    return r;
  endfunction

endpackage

// ===== src/hsc_front.sv =====
// front end: accepts input beats, decodes the operation, queues commands
module hsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [5:0]        in_x_pos,
  input  logic [5:0]        in_y_pos,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output hsc_pkg::cmd_t     cmd
);

  hsc_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;
  hsc_pkg::cmd_t dec;

  // decode the function code
  always_comb begin
    dec.x_pos = in_x_pos;
    dec.y_pos = in_y_pos;
    unique case (in_func)
      2'd0:    dec.op = hsc_pkg::OP_CLEAR;
      2'd1:    dec.op = hsc_pkg::OP_DROP;
      2'd2:    dec.op = hsc_pkg::OP_READ;
      default: dec.op = hsc_pkg::OP_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= dec;
  end

endmodule

// ===== src/hsc_back.sv =====
// back end: grid memory, clear sweep, cone walker, divider and classifier
module hsc_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RADIUS = 15,
  parameter int CELL_BITS  = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  hsc_pkg::cmd_t              cmd,
  input  hsc_pkg::cfg_t              cfg,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hsc_pkg::RAW_W-1:0]  out_raw_level,
  output logic [7:0]                 out_scaled_level,
  output logic [2:0]                 out_terrain_class,
  output logic [hsc_pkg::RAW_W-1:0]  out_peak_level
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = CELL_BITS + 8;
  localparam logic [CELL_BITS-1:0] CELL_MAX = {CELL_BITS{1'b1}};

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_MOD  = 3'd3;
  localparam logic [2:0] ST_RDW  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_CLS  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]           st_r;
  logic                 clr_res_r;
  logic [AW-1:0]        addr_r;
  logic [CELL_BITS-1:0] peak_r;
  logic [5:0]           cx_r, cy_r;
  logic signed [5:0]    dx_r, dy_r;
  logic [7:0]           amt_r;
  logic [CELL_BITS-1:0] raw_r;
  logic [NW-1:0]        rem_r, dvs_r;
  logic [7:0]           quo_r;
  logic [2:0]           cnt_r;
  logic [7:0]           res_scl_r;
  logic [2:0]           res_cls_r;
  logic                 out_valid_r;
  logic [hsc_pkg::RAW_W-1:0] out_raw_r, out_peak_r;
  logic [7:0]           out_scl_r;
  logic [2:0]           out_cls_r;

  // grid memory
  logic [CELL_BITS-1:0] mem [DEPTH];
  logic [CELL_BITS-1:0] rd_data_r;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [CELL_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // effective radius
  logic [3:0]        rad;
  logic signed [5:0] rad_s;
  assign rad   = (int'(cfg.splat_radius) > MAX_RADIUS) ? 4'(MAX_RADIUS) : cfg.splat_radius;
  assign rad_s = signed'({2'b00, rad});

  // cone cell position and bounds
  logic signed [7:0]  xs, ys;
  logic               x_in, y_in;
  logic signed [11:0] dxx, dyy;
  logic [9:0]         d2;
  logic [7:0]         rr;
  logic [3:0]         cone_dist;
  logic               hit, last_cell;
  logic [AW-1:0]      cell_addr;
  logic [7:0]         amt;

  always_comb begin
    xs   = signed'({2'b00, cx_r}) + {{2{dx_r[5]}}, dx_r};
    ys   = signed'({2'b00, cy_r}) + {{2{dy_r[5]}}, dy_r};
    x_in = !xs[7] && (xs[6:0] < cfg.grid_width) && (int'(xs[6:0]) < MAX_WIDTH);
    y_in = !ys[7] && (ys[6:0] < cfg.grid_height) && (int'(ys[6:0]) < MAX_HEIGHT);
    dxx  = dx_r * dx_r;
    dyy  = dy_r * dy_r;
    d2   = 10'(dxx) + 10'(dyy);
    rr   = {4'b0, rad} * {4'b0, rad};
    cone_dist = hsc_pkg::isqrt8(d2[7:0]);
    amt  = cfg.splat_power - {4'b0, cone_dist};
    hit  = x_in && y_in && (d2 <= {2'b00, rr}) && (cfg.splat_power > {4'b0, cone_dist});
    cell_addr = AW'(int'(ys[6:0]) * MAX_WIDTH + int'(xs[6:0]));
    last_cell = (dx_r == rad_s) && (dy_r == rad_s);
  end

  // read position bounds
  logic          rd_in;
  logic [AW-1:0] rd_cell;
  always_comb begin
    rd_in   = ({1'b0, cmd.x_pos} < cfg.grid_width) && (int'(cmd.x_pos) < MAX_WIDTH)
           && ({1'b0, cmd.y_pos} < cfg.grid_height) && (int'(cmd.y_pos) < MAX_HEIGHT);
    rd_cell = AW'(int'(cmd.y_pos) * MAX_WIDTH + int'(cmd.x_pos));
  end

  // saturating add for the modify step
  logic [CELL_BITS:0]   sum;
  logic [CELL_BITS-1:0] new_cell;
  assign sum      = {1'b0, rd_data_r} + (CELL_BITS+1)'(amt_r);
  assign new_cell = sum[CELL_BITS] ? CELL_MAX : sum[CELL_BITS-1:0];

  // raw * 255 and one divider step
  logic [NW-1:0] num;
  logic          ge;
  assign num = {rd_data_r, 8'b0} - NW'(rd_data_r);
  assign ge  = (rem_r >= dvs_r);

  // class thresholds, two register stages from the water level
  logic [7:0]  lz;
  logic [14:0] n15_r, n40_r, n80_r;
  logic [8:0]  th_coast_r, th_plains_r, th_forest_r;
  logic [27:0] p15, p40, p80;
  assign lz  = 8'd255 - cfg.water_level;
  assign p15 = 28'(n15_r) * 28'(hsc_pkg::RECIP_100);
  assign p40 = 28'(n40_r) * 28'(hsc_pkg::RECIP_100);
  assign p80 = 28'(n80_r) * 28'(hsc_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    n15_r       <= 15'(lz) * 15'd15;
    n40_r       <= 15'(lz) * 15'd40;
    n80_r       <= 15'(lz) * 15'd80;
    th_coast_r  <= {1'b0, cfg.water_level} + 9'(p15 >> hsc_pkg::RECIP_SHIFT);
    th_plains_r <= {1'b0, cfg.water_level} + 9'(p40 >> hsc_pkg::RECIP_SHIFT);
    th_forest_r <= {1'b0, cfg.water_level} + 9'(p80 >> hsc_pkg::RECIP_SHIFT);
  end

  // terrain class of the quotient
  logic [2:0] cls;
  logic [8:0] s9;
  assign s9 = {1'b0, quo_r};
  always_comb begin
    priority if (quo_r < (cfg.water_level >> 1)) cls = hsc_pkg::CLS_DEEP;
    else if (quo_r <= cfg.water_level)          cls = hsc_pkg::CLS_SHALLOW;
    else if (s9 < th_coast_r)                   cls = hsc_pkg::CLS_COAST;
    else if (s9 < th_plains_r)                  cls = hsc_pkg::CLS_PLAINS;
    else if (s9 < th_forest_r)                  cls = hsc_pkg::CLS_FOREST;
    else                                        cls = hsc_pkg::CLS_MOUNTAIN;
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cell_addr;
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = new_cell;
    unique case (st_r)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      ST_IDLE: begin
        rd_en   = cmd_valid && (cmd.op == hsc_pkg::OP_READ);
        rd_addr = rd_cell;
      end
      ST_SCAN: rd_en = hit;
      ST_MOD:  wr_en = 1'b1;
      default: ;
    endcase
  end

  assign cmd_ready = (st_r == ST_IDLE);
  logic out_load;
  assign out_load = (st_r == ST_OUT) && (!out_valid_r || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_res_r   <= 1'b0;
      addr_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_CLR: begin
          addr_r <= addr_r + AW'(1);
          if (int'(addr_r) == DEPTH - 1) begin
            st_r <= clr_res_r ? ST_OUT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            raw_r     <= '0;
            res_scl_r <= '0;
            res_cls_r <= hsc_pkg::CLS_DEEP;
            cx_r      <= cmd.x_pos;
            cy_r      <= cmd.y_pos;
            dx_r      <= -rad_s;
            dy_r      <= -rad_s;
            unique case (cmd.op)
              hsc_pkg::OP_CLEAR: begin
                peak_r    <= '0;
                addr_r    <= '0;
                clr_res_r <= 1'b1;
                st_r      <= ST_CLR;
              end
              hsc_pkg::OP_DROP: st_r <= ST_SCAN;
              hsc_pkg::OP_READ: st_r <= rd_in ? ST_RDW : ST_OUT;
              default:          st_r <= ST_OUT;
            endcase
          end
        end
        ST_SCAN, ST_MOD: begin
          if (st_r == ST_SCAN && hit) begin
            addr_r <= cell_addr;
            amt_r  <= amt;
            st_r   <= ST_MOD;
          end else begin
            if (st_r == ST_MOD && new_cell > peak_r) peak_r <= new_cell;
            // step to the next cell of the square
            if (dx_r == rad_s) begin
              dx_r <= -rad_s;
              dy_r <= dy_r + 6'sd1;
            end else begin
              dx_r <= dx_r + 6'sd1;
            end
            st_r <= last_cell ? ST_OUT : ST_SCAN;
          end
        end
        ST_RDW: begin
          raw_r <= rd_data_r;
          quo_r <= '0;
          rem_r <= num;
          dvs_r <= {1'b0, peak_r, 7'b0};
          cnt_r <= 3'd7;
          st_r  <= (peak_r == '0) ? ST_CLS : ST_DIV;
        end
        ST_DIV: begin
          if (ge) rem_r <= rem_r - dvs_r;
          quo_r <= {quo_r[6:0], ge};
          dvs_r <= dvs_r >> 1;
          cnt_r <= cnt_r - 3'd1;
          if (cnt_r == 3'd0) st_r <= ST_CLS;
        end
        ST_CLS: begin
          res_scl_r <= quo_r;
          res_cls_r <= cls;
          st_r      <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            clr_res_r <= 1'b0;
            st_r      <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_raw_r  <= hsc_pkg::RAW_W'(raw_r);
      out_scl_r  <= res_scl_r;
      out_cls_r  <= res_cls_r;
      out_peak_r <= hsc_pkg::RAW_W'(peak_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_raw_level     = out_raw_r;
  assign out_scaled_level  = out_scl_r;
  assign out_terrain_class = out_cls_r;
  assign out_peak_level    = out_peak_r;

endmodule

// ===== src/heightmap_splat_classifier.sv =====
// Heightmap splat classifier: a MAX_WIDTH x MAX_HEIGHT grid of CELL_BITS-wide
// heights with a running peak. Each input beat is clear, drop, read or no-op,
// and gives exactly one output beat. After reset the grid memory is swept to
// zero cell by cell before the first command is taken; a clear runs the
// same sweep and also zeroes the peak. A drop walks the (2r+1)^2 square around
// the centre, r being the radius capped at MAX_RADIUS, reading then writing
// each cell inside the cone and grid. A read inside the grid runs a memory
// read, eight divider steps for raw*255/peak (none for a zero peak), then
// classification. Commands queue two deep in front, and the result sits in an
// output register, so input and output stall independently. Configuration
// writes are accepted every cycle and must only be issued while the block is
// idle.
module heightmap_splat_classifier #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RADIUS = 15,
  parameter int CELL_BITS  = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [5:0]                in_x_pos,
  input  logic [5:0]                in_y_pos,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hsc_pkg::RAW_W-1:0] out_raw_level,
  output logic [7:0]                out_scaled_level,
  output logic [2:0]                out_terrain_class,
  output logic [hsc_pkg::RAW_W-1:0] out_peak_level,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [7:0]                cfg_data
);

  hsc_pkg::cfg_t cfg_r;
  hsc_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width   <= 7'd64;
      cfg_r.grid_height  <= 7'd64;
      cfg_r.water_level  <= 8'd100;
      cfg_r.splat_radius <= 4'd2;
      cfg_r.splat_power  <= 8'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hsc_pkg::CFG_GRID_WIDTH:   cfg_r.grid_width   <= cfg_data[6:0];
        hsc_pkg::CFG_GRID_HEIGHT:  cfg_r.grid_height  <= cfg_data[6:0];
        hsc_pkg::CFG_WATER_LEVEL:  cfg_r.water_level  <= cfg_data;
        hsc_pkg::CFG_SPLAT_RADIUS: cfg_r.splat_radius <= cfg_data[3:0];
        hsc_pkg::CFG_SPLAT_POWER:  cfg_r.splat_power  <= cfg_data;
        default: ;
      endcase
    end
  end

  // command front end
  hsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_x_pos  (in_x_pos),
    .in_y_pos  (in_y_pos),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // grid back end
  hsc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .CELL_BITS  (CELL_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd),
    .cfg               (cfg_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_raw_level     (out_raw_level),
    .out_scaled_level  (out_scaled_level),
    .out_terrain_class (out_terrain_class),
    .out_peak_level    (out_peak_level)
  );

endmodule
